// ----- design/nrtp_pkg.sv -----
// types and constants shared by the numeric range text parser
`default_nettype none

package nrtp_pkg;

   // fixed width of the bound fields on the result channel
   localparam int unsigned BOUND_WIDTH = 64;
   localparam int unsigned CHAR_WIDTH  = 8;
   localparam int unsigned RADIX       = 10;

   localparam logic [CHAR_WIDTH-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_WIDTH-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;

   typedef enum logic [2:0] {
      PH_START,
      PH_SPACE,
      PH_NUM1,
      PH_DASH,
      PH_NUM2,
      PH_NEGLEAD,
      PH_ERROR
   } phase_type;

   typedef struct packed {
      phase_type phase;
      logic      negate_first;
      logic      digits_seen;
   } ctl_type;

   typedef struct packed {
      logic is_valid;
      logic has_lower;
      logic has_upper;
   } flag_type;

endpackage

`default_nettype wire

// ----- design/nrtp_req_if.sv -----
// request channel: one text byte per word
`default_nettype none

interface nrtp_req_if;
   logic                                valid;
   logic                                ready;
   logic [nrtp_pkg::CHAR_WIDTH-1:0]     text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

`default_nettype wire

// ----- design/nrtp_rsp_if.sv -----
// response channel: parse flags and the two bound values
`default_nettype none

interface nrtp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 is_valid;
   logic                                 has_lower;
   logic                                 has_upper;
   logic [nrtp_pkg::BOUND_WIDTH-1:0]     lower_value;
   logic [nrtp_pkg::BOUND_WIDTH-1:0]     upper_value;

   modport source (output valid, output is_valid, output has_lower, output has_upper,
                   output lower_value, output upper_value, input ready);
   modport sink   (input valid, input is_valid, input has_lower, input has_upper,
                   input lower_value, input upper_value, output ready);
endinterface

`default_nettype wire

// ----- design/numeric_range_text_parser_unit.sv -----
// top level of the numeric range text parser
//
//   channel  dir  word                           handshake
//   req_ch   in   text_byte (8b), 0 ends string  valid/ready
//   rsp_ch   out  flags + lower/upper (64b)      valid/ready
//
// one byte is taken every cycle while the byte register is not held; the parse step is a
// multiply-by-ten and add between the byte register and the state registers
// a result is written to the response register when its terminator byte retires from the byte register
// synchronous active-high reset returns the parser to the start of a string
// the byte register only holds when a terminator meets a full, unread response
`default_nettype none

module numeric_range_text_parser_unit #(
   parameter int unsigned VALUE_BITS = 64
) (
   input  wire logic     clock,
   input  wire logic     reset,
   nrtp_req_if.sink      req_ch,
   nrtp_rsp_if.source    rsp_ch
);

   // input byte register
   logic                              byte_vld_ff, byte_vld_in;
   logic [nrtp_pkg::CHAR_WIDTH-1:0]   byte_ff, byte_in;

   // parse state
   nrtp_pkg::ctl_type                 ctl_ff, ctl_in;
   logic [VALUE_BITS-1:0]             acc_ff, acc_in;
   logic [VALUE_BITS-1:0]             first_ff, first_in;

   // response register
   logic                              rsp_vld_ff, rsp_vld_in;
   nrtp_pkg::flag_type                flags_ff, flags_in;
   logic [VALUE_BITS-1:0]             lower_ff, lower_in;
   logic [VALUE_BITS-1:0]             upper_ff, upper_in;

   nrtp_pkg::ctl_type                 step_ctl;
   logic [VALUE_BITS-1:0]             step_acc;
   logic [VALUE_BITS-1:0]             step_first;
   logic                              step_term;
   nrtp_pkg::flag_type                step_flags;
   logic [VALUE_BITS-1:0]             step_lower;
   logic [VALUE_BITS-1:0]             step_upper;

   logic                              req_take;
   logic                              fire;

   nrtp_step #(
      .VALUE_BITS (VALUE_BITS)
   ) u_step (
      .ctl       (ctl_ff),
      .acc       (acc_ff),
      .first     (first_ff),
      .text_byte (byte_ff),
      .ctl_in    (step_ctl),
      .acc_in    (step_acc),
      .first_in  (step_first),
      .is_term   (step_term),
      .flags     (step_flags),
      .lower     (step_lower),
      .upper     (step_upper)
   );

   // a non-terminator byte always retires; a terminator needs room in the response reg
   assign fire     = byte_vld_ff && (!step_term || !rsp_vld_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !byte_vld_ff || fire;

   always_comb begin
      byte_vld_in = byte_vld_ff;
      byte_in     = byte_ff;
      if (req_take) begin
         byte_vld_in = 1'b1;
         byte_in     = req_ch.text_byte;
      end else if (fire) begin
         byte_vld_in = 1'b0;
      end

      ctl_in   = ctl_ff;
      acc_in   = acc_ff;
      first_in = first_ff;
      if (fire) begin
         ctl_in   = step_ctl;
         acc_in   = step_acc;
         first_in = step_first;
      end

      rsp_vld_in = rsp_vld_ff;
      flags_in   = flags_ff;
      lower_in   = lower_ff;
      upper_in   = upper_ff;
      if (fire && step_term) begin
         rsp_vld_in = 1'b1;
         flags_in   = step_flags;
         lower_in   = step_lower;
         upper_in   = step_upper;
      end else if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_vld_ff <= 1'b0;
         ctl_ff      <= '{phase: nrtp_pkg::PH_START, negate_first: 1'b0, digits_seen: 1'b0};
         acc_ff      <= '0;
         first_ff    <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         byte_vld_ff <= byte_vld_in;
         ctl_ff      <= ctl_in;
         acc_ff      <= acc_in;
         first_ff    <= first_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      flags_ff <= flags_in;
      lower_ff <= lower_in;
      upper_ff <= upper_in;
   end

   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.is_valid    = flags_ff.is_valid;
   assign rsp_ch.has_lower   = flags_ff.has_lower;
   assign rsp_ch.has_upper   = flags_ff.has_upper;
   assign rsp_ch.lower_value = nrtp_pkg::BOUND_WIDTH'(lower_ff);
   assign rsp_ch.upper_value = nrtp_pkg::BOUND_WIDTH'(upper_ff);

   // an invalid string reports no bounds and zero values
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !flags_ff.is_valid |->
         !flags_ff.has_lower && !flags_ff.has_upper && lower_ff == '0 && upper_ff == '0)
      else $error("invalid response carries bounds");

   // absent bounds read as zero
   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (flags_ff.has_lower || lower_ff == '0) &&
                     (flags_ff.has_upper || upper_ff == '0))
      else $error("absent bound is not zero");

   // a retired terminator leaves a clean start state
   a_term_clears: assert property (@(posedge clock) disable iff (reset)
      fire && step_term |=>
         ctl_ff.phase == nrtp_pkg::PH_START && !ctl_ff.digits_seen &&
         !ctl_ff.negate_first && acc_ff == '0 && first_ff == '0)
      else $error("state not cleared after terminator");

   // start of string implies nothing accumulated
   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.phase == nrtp_pkg::PH_START |->
         acc_ff == '0 && !ctl_ff.digits_seen && !ctl_ff.negate_first)
      else $error("start phase with leftover state");

   // a held byte is not overwritten before it retires
   a_byte_hold: assert property (@(posedge clock) disable iff (reset)
      byte_vld_ff && !fire |=> byte_vld_ff && $stable(byte_ff))
      else $error("pending byte lost");

endmodule

`default_nettype wire

// ----- design/nrtp_step.sv -----
// next-state and result logic for one text byte
`default_nettype none

module nrtp_step #(
   parameter int unsigned VALUE_BITS = 64
) (
   input  wire nrtp_pkg::ctl_type                  ctl,
   input  wire logic [VALUE_BITS-1:0]             acc,
   input  wire logic [VALUE_BITS-1:0]             first,
   input  wire logic [nrtp_pkg::CHAR_WIDTH-1:0]   text_byte,
   output nrtp_pkg::ctl_type                       ctl_in,
   output logic [VALUE_BITS-1:0]                  acc_in,
   output logic [VALUE_BITS-1:0]                  first_in,
   output logic                                   is_term,
   output nrtp_pkg::flag_type                      flags,
   output logic [VALUE_BITS-1:0]                  lower,
   output logic [VALUE_BITS-1:0]                  upper
);

   localparam int unsigned ExtW = VALUE_BITS + 4;

   logic              is_digit;
   logic              is_space;
   logic [3:0]        digit;
   logic [ExtW-1:0]   prod;
   logic              take_ok;
   logic [VALUE_BITS-1:0] first_val;

   assign is_digit = (text_byte inside {[nrtp_pkg::CHAR_ZERO:nrtp_pkg::CHAR_NINE]});
   assign is_space = (text_byte inside {[nrtp_pkg::CHAR_TAB:nrtp_pkg::CHAR_CR],
                                        nrtp_pkg::CHAR_SPACE});
   assign digit    = 4'(text_byte - nrtp_pkg::CHAR_ZERO);

   // acc * 10 + d, overflow if anything lands above the value width
   assign prod    = ExtW'(acc) * ExtW'(nrtp_pkg::RADIX) + ExtW'(digit);
   assign take_ok = is_digit && (prod[ExtW-1:VALUE_BITS] == '0);

   assign first_val = ctl.negate_first ? (VALUE_BITS'(0) - acc) : acc;
   assign is_term   = (text_byte == nrtp_pkg::CHAR_NUL);

   always_comb begin
      ctl_in   = ctl;
      acc_in   = acc;
      first_in = first;
      flags    = '0;
      lower    = '0;
      upper    = '0;
      if (is_term) begin
         case (ctl.phase)
            nrtp_pkg::PH_NUM1: begin
               if (ctl.digits_seen) begin
                  flags = '{is_valid: 1'b1, has_lower: 1'b1, has_upper: 1'b1};
                  lower = first_val;
                  upper = first_val;
               end
            end
            nrtp_pkg::PH_DASH: begin
               flags = '{is_valid: 1'b1, has_lower: 1'b1, has_upper: 1'b0};
               lower = first;
            end
            nrtp_pkg::PH_NUM2: begin
               flags = '{is_valid: 1'b1, has_lower: 1'b1, has_upper: 1'b1};
               lower = first;
               upper = acc;
            end
            nrtp_pkg::PH_NEGLEAD: begin
               if (ctl.digits_seen) begin
                  flags = '{is_valid: 1'b1, has_lower: 1'b0, has_upper: 1'b1};
                  upper = acc;
               end
            end
            default: ;
         endcase
         // back to the start of a new string
         ctl_in   = '{phase: nrtp_pkg::PH_START, negate_first: 1'b0, digits_seen: 1'b0};
         acc_in   = '0;
         first_in = '0;
      end else begin
         ctl_in.phase = nrtp_pkg::PH_ERROR;
         case (ctl.phase)
            nrtp_pkg::PH_START: begin
               if (text_byte == nrtp_pkg::CHAR_MINUS) begin
                  ctl_in.phase = nrtp_pkg::PH_NEGLEAD;
               end else if (is_space) begin
                  ctl_in.phase = nrtp_pkg::PH_SPACE;
               end else if (text_byte == nrtp_pkg::CHAR_PLUS) begin
                  ctl_in.phase = nrtp_pkg::PH_NUM1;
               end else if (take_ok) begin
                  acc_in             = prod[VALUE_BITS-1:0];
                  ctl_in.digits_seen = 1'b1;
                  ctl_in.phase       = nrtp_pkg::PH_NUM1;
               end
            end
            nrtp_pkg::PH_SPACE: begin
               if (is_space) begin
                  ctl_in.phase = nrtp_pkg::PH_SPACE;
               end else if (text_byte == nrtp_pkg::CHAR_PLUS) begin
                  ctl_in.phase = nrtp_pkg::PH_NUM1;
               end else if (text_byte == nrtp_pkg::CHAR_MINUS) begin
                  ctl_in.negate_first = 1'b1;
                  ctl_in.phase        = nrtp_pkg::PH_NUM1;
               end else if (take_ok) begin
                  acc_in             = prod[VALUE_BITS-1:0];
                  ctl_in.digits_seen = 1'b1;
                  ctl_in.phase       = nrtp_pkg::PH_NUM1;
               end
            end
            nrtp_pkg::PH_NUM1: begin
               if (take_ok) begin
                  acc_in             = prod[VALUE_BITS-1:0];
                  ctl_in.digits_seen = 1'b1;
                  ctl_in.phase       = nrtp_pkg::PH_NUM1;
               end else if (text_byte == nrtp_pkg::CHAR_MINUS && ctl.digits_seen) begin
                  first_in           = first_val;
                  acc_in             = '0;
                  ctl_in.digits_seen = 1'b0;
                  ctl_in.phase       = nrtp_pkg::PH_DASH;
               end
            end
            nrtp_pkg::PH_DASH, nrtp_pkg::PH_NUM2: begin
               if (take_ok) begin
                  acc_in             = prod[VALUE_BITS-1:0];
                  ctl_in.digits_seen = 1'b1;
                  ctl_in.phase       = nrtp_pkg::PH_NUM2;
               end
            end
            nrtp_pkg::PH_NEGLEAD: begin
               if (take_ok) begin
                  acc_in             = prod[VALUE_BITS-1:0];
                  ctl_in.digits_seen = 1'b1;
                  ctl_in.phase       = nrtp_pkg::PH_NEGLEAD;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- tb/numeric_range_text_parser_unit_tb.sv -----
// self-checking regression of the numeric range text parser against a local parser model
`default_nettype none

module numeric_range_text_parser_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned VALUE_BITS   = 64;
   localparam int          CLOCK_PERIOD = 10;
   localparam int          RESET_CYCLES = 12;
   // words offered at least, directed strings included; the stream may run slightly over
   localparam int          STREAM_BYTES = 1850;
   localparam int          IDLE_PERCENT = 16;
   // no idling on either side inside this window of cycles
   localparam int          QUIET_FIRST  = 1200;
   localparam int          QUIET_LAST   = 1800;
   // long receiver hold-off so the parser backs up and stalls its input
   localparam int          HOLD_START   = 500;
   localparam int          HOLD_CYCLES  = 300;
   // margin after the last result comes back, before the verdict
   localparam int          DRAIN_CYCLES = 8;
   localparam int          LIMIT_CYCLES = 100000;
   localparam int          REPORT_LIMIT = 10;

   localparam logic [nrtp_pkg::BOUND_WIDTH-1:0] VALUE_MAX =
      {nrtp_pkg::BOUND_WIDTH{1'b1}} >> (nrtp_pkg::BOUND_WIDTH - VALUE_BITS);

   typedef logic [nrtp_pkg::CHAR_WIDTH-1:0] char_type;

   // one result word as the response channel carries it
   typedef struct packed {
      nrtp_pkg::flag_type               flags;
      logic [nrtp_pkg::BOUND_WIDTH-1:0] lower_value;
      logic [nrtp_pkg::BOUND_WIDTH-1:0] upper_value;
   } bound_result_type;

   logic clock = 1'b0;
   logic reset;

   nrtp_req_if req_ch ();
   nrtp_rsp_if rsp_ch ();

   numeric_range_text_parser_unit #(
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always #(CLOCK_PERIOD / 2.0) clock = ~clock;

   // text bytes still to be offered, terminators included
   char_type         text_stream[$];
   // parse results the block still owes, oldest first
   bound_result_type pending_bounds[$];

   int   cycle_count = 0;
   int   fault_count = 0;
   int   hold_left   = 0;
   logic req_fired   = 1'b0;

   // local copy of the parser state
   nrtp_pkg::phase_type              parse_phase;
   logic [nrtp_pkg::BOUND_WIDTH-1:0] digit_accum;
   logic [nrtp_pkg::BOUND_WIDTH-1:0] first_bound;
   logic                             negate_first;
   logic                             digits_seen;

   // ---------------------------------------------------------------------------------------------
   // parser model
   // ---------------------------------------------------------------------------------------------

   function automatic bit is_digit(input char_type c);
      return c >= nrtp_pkg::CHAR_ZERO && c <= nrtp_pkg::CHAR_NINE;
   endfunction

   // space, tab, newline, vertical tab, form feed, carriage return
   function automatic bit is_blank(input char_type c);
      return c == nrtp_pkg::CHAR_SPACE || (c >= nrtp_pkg::CHAR_TAB && c <= nrtp_pkg::CHAR_CR);
   endfunction

   function automatic void clear_parser();
      parse_phase  = nrtp_pkg::PH_START;
      digit_accum  = '0;
      first_bound  = '0;
      negate_first = 1'b0;
      digits_seen  = 1'b0;
   endfunction

   // append one decimal digit, refuse it when the value would pass VALUE_MAX
   function automatic bit take_digit(input char_type c);
      logic [nrtp_pkg::BOUND_WIDTH-1:0] d;
      d = nrtp_pkg::BOUND_WIDTH'(c - nrtp_pkg::CHAR_ZERO);
      if (digit_accum > (VALUE_MAX - d) / nrtp_pkg::RADIX)
         return 1'b0;
      digit_accum = digit_accum * nrtp_pkg::RADIX + d;
      digits_seen = 1'b1;
      return 1'b1;
   endfunction

   // leading minus after blanks negates modulo 2^VALUE_BITS
   function automatic logic [nrtp_pkg::BOUND_WIDTH-1:0] first_value();
      if (negate_first)
         return (nrtp_pkg::BOUND_WIDTH'(0) - digit_accum) & VALUE_MAX;
      return digit_accum;
   endfunction

   // step the model by one accepted byte; a terminator always yields a result
   function automatic void advance_parser(input char_type c, output bit produced,
                                          output bound_result_type res);
      nrtp_pkg::phase_type next;
      next     = nrtp_pkg::PH_ERROR;
      produced = 1'b0;
      res      = '0;
      if (c == nrtp_pkg::CHAR_NUL) begin
         produced = 1'b1;
         case (parse_phase)
            nrtp_pkg::PH_NUM1: begin
               if (digits_seen) begin
                  res.flags       = '{is_valid: 1'b1, has_lower: 1'b1, has_upper: 1'b1};
                  res.lower_value = first_value();
                  res.upper_value = first_value();
               end
            end
            nrtp_pkg::PH_DASH: begin
               res.flags       = '{is_valid: 1'b1, has_lower: 1'b1, has_upper: 1'b0};
               res.lower_value = first_bound;
            end
            nrtp_pkg::PH_NUM2: begin
               res.flags       = '{is_valid: 1'b1, has_lower: 1'b1, has_upper: 1'b1};
               res.lower_value = first_bound;
               res.upper_value = digit_accum;
            end
            nrtp_pkg::PH_NEGLEAD: begin
               if (digits_seen) begin
                  res.flags       = '{is_valid: 1'b1, has_lower: 1'b0, has_upper: 1'b1};
                  res.upper_value = digit_accum;
               end
            end
            default: begin
            end
         endcase
         clear_parser();
         return;
      end
      case (parse_phase)
         nrtp_pkg::PH_START: begin
            // a minus straight at the start marks an upper bound only
            if (c == nrtp_pkg::CHAR_MINUS) next = nrtp_pkg::PH_NEGLEAD;
            else if (is_blank(c)) next = nrtp_pkg::PH_SPACE;
            else if (c == nrtp_pkg::CHAR_PLUS) next = nrtp_pkg::PH_NUM1;
            else if (is_digit(c) && take_digit(c)) next = nrtp_pkg::PH_NUM1;
         end
         nrtp_pkg::PH_SPACE: begin
            if (is_blank(c)) next = nrtp_pkg::PH_SPACE;
            else if (c == nrtp_pkg::CHAR_PLUS) next = nrtp_pkg::PH_NUM1;
            else if (c == nrtp_pkg::CHAR_MINUS) begin
               negate_first = 1'b1;
               next         = nrtp_pkg::PH_NUM1;
            end
            else if (is_digit(c) && take_digit(c)) next = nrtp_pkg::PH_NUM1;
         end
         nrtp_pkg::PH_NUM1: begin
            if (is_digit(c)) begin
               if (take_digit(c)) next = nrtp_pkg::PH_NUM1;
            end else if (c == nrtp_pkg::CHAR_MINUS && digits_seen) begin
               first_bound = first_value();
               digit_accum = '0;
               digits_seen = 1'b0;
               next        = nrtp_pkg::PH_DASH;
            end
         end
         nrtp_pkg::PH_DASH, nrtp_pkg::PH_NUM2: begin
            if (is_digit(c) && take_digit(c)) next = nrtp_pkg::PH_NUM2;
         end
         nrtp_pkg::PH_NEGLEAD: begin
            if (is_digit(c) && take_digit(c)) next = nrtp_pkg::PH_NEGLEAD;
         end
         default: begin
         end
      endcase
      parse_phase = next;
   endfunction

   // ---------------------------------------------------------------------------------------------
   // stimulus builders
   // ---------------------------------------------------------------------------------------------

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++)
         text_stream.push_back(char_type'(s[i]));
   endtask

   task automatic put_string(input string s);
      put_text(s);
      text_stream.push_back(nrtp_pkg::CHAR_NUL);
   endtask

   task automatic put_digit();
      text_stream.push_back(nrtp_pkg::CHAR_ZERO +
                            char_type'($urandom_range(0, nrtp_pkg::RADIX - 1)));
   endtask

   // mostly short numbers, with the overflow edge and long runs mixed in
   task automatic put_number();
      case ($urandom_range(0, 11))
         0: put_text("18446744073709551615");
         1: put_text("18446744073709551616");
         2: begin
            put_text("1");
            repeat (19) put_digit();
         end
         3: repeat ($urandom_range(21, 24)) put_digit();
         default: repeat ($urandom_range(1, 6)) put_digit();
      endcase
   endtask

   // optional blanks, then an optional sign; a minus only negates after blanks
   task automatic put_prefix();
      int blanks;
      int pick;
      blanks = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
      repeat (blanks) begin
         pick = $urandom_range(0, 5);
         text_stream.push_back((pick == 0) ? nrtp_pkg::CHAR_SPACE :
                               nrtp_pkg::CHAR_TAB + char_type'(pick - 1));
      end
      if (blanks != 0) begin
         case ($urandom_range(0, 2))
            1: text_stream.push_back(nrtp_pkg::CHAR_PLUS);
            2: text_stream.push_back(nrtp_pkg::CHAR_MINUS);
            default: begin
            end
         endcase
      end else if ($urandom_range(0, 3) == 0) begin
         text_stream.push_back(nrtp_pkg::CHAR_PLUS);
      end
   endtask

   // one of the four range forms; a broken one gets a stray byte somewhere
   task automatic put_range_string(input bit broken);
      int first;
      int spot;
      first = text_stream.size();
      case ($urandom_range(0, 3))
         0: begin
            put_prefix();
            put_number();
         end
         1: begin
            text_stream.push_back(nrtp_pkg::CHAR_MINUS);
            put_number();
         end
         2: begin
            put_prefix();
            put_number();
            text_stream.push_back(nrtp_pkg::CHAR_MINUS);
         end
         default: begin
            put_prefix();
            put_number();
            text_stream.push_back(nrtp_pkg::CHAR_MINUS);
            put_number();
         end
      endcase
      if (broken) begin
         spot = $urandom_range(first, text_stream.size());
         text_stream.insert(spot, char_type'($urandom_range(1, 255)));
      end
      text_stream.push_back(nrtp_pkg::CHAR_NUL);
   endtask

   // random non-zero bytes, so every bit of the byte toggles
   task automatic put_noise();
      repeat ($urandom_range(0, 8)) text_stream.push_back(char_type'($urandom_range(1, 255)));
      text_stream.push_back(nrtp_pkg::CHAR_NUL);
   endtask

   // idle roll shared by both sides, off inside the quiet window
   function automatic bit idle_roll();
      if (cycle_count >= QUIET_FIRST && cycle_count <= QUIET_LAST)
         return 1'b0;
      return $urandom_range(0, 99) < IDLE_PERCENT;
   endfunction

   // ---------------------------------------------------------------------------------------------
   // request driver: a word stays on the channel until it is taken
   // ---------------------------------------------------------------------------------------------

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.text_byte <= nrtp_pkg::CHAR_NUL;
      end else if (!req_ch.valid || req_fired) begin
         // last word gone (or none offered), pick the next or idle
         if (text_stream.size() != 0 && !idle_roll()) begin
            req_ch.valid     <= 1'b1;
            req_ch.text_byte <= text_stream.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------------------------
   // response receiver and its long hold-off
   // ---------------------------------------------------------------------------------------------

   always @(negedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (cycle_count == HOLD_START)
         hold_left <= HOLD_CYCLES;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   always @(negedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= (hold_left == 0) && !idle_roll();
   end

   // ---------------------------------------------------------------------------------------------
   // monitor: check results against the oldest pending one, then model new bytes
   // ---------------------------------------------------------------------------------------------

   bound_result_type seen_bounds;
   bound_result_type next_bounds;
   bit               produced;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_fired <= 1'b0;
         clear_parser();
      end else begin
         req_fired <= req_ch.valid && req_ch.ready;

         // result words first: a result leaving now is older than any byte taken now
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen_bounds.flags       = '{is_valid: rsp_ch.is_valid, has_lower: rsp_ch.has_lower,
                                        has_upper: rsp_ch.has_upper};
            seen_bounds.lower_value = rsp_ch.lower_value;
            seen_bounds.upper_value = rsp_ch.upper_value;
            if (pending_bounds.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("%0t: unexpected result valid=%b lower=%b/%h upper=%b/%h", $realtime,
                           seen_bounds.flags.is_valid, seen_bounds.flags.has_lower,
                           seen_bounds.lower_value, seen_bounds.flags.has_upper,
                           seen_bounds.upper_value);
            end else begin
               next_bounds = pending_bounds.pop_front();
               if (seen_bounds.flags.is_valid  !== next_bounds.flags.is_valid  ||
                   seen_bounds.flags.has_lower !== next_bounds.flags.has_lower ||
                   seen_bounds.flags.has_upper !== next_bounds.flags.has_upper ||
                   seen_bounds.lower_value     !== next_bounds.lower_value     ||
                   seen_bounds.upper_value     !== next_bounds.upper_value) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT)
                     $display({"%0t: result mismatch valid %b/%b has_lower %b/%b ",
                               "has_upper %b/%b lower %h/%h upper %h/%h (expected/actual)"},
                              $realtime,
                              next_bounds.flags.is_valid, seen_bounds.flags.is_valid,
                              next_bounds.flags.has_lower, seen_bounds.flags.has_lower,
                              next_bounds.flags.has_upper, seen_bounds.flags.has_upper,
                              next_bounds.lower_value, seen_bounds.lower_value,
                              next_bounds.upper_value, seen_bounds.upper_value);
               end
            end
         end

         // every accepted byte steps the model; only a terminator adds an expectation
         if (req_ch.valid && req_ch.ready) begin
            advance_parser(req_ch.text_byte, produced, next_bounds);
            if (produced)
               pending_bounds.push_back(next_bounds);
         end
      end
   end

   // ---------------------------------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------------------------------

   initial begin : stimulus
      int kind;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.text_byte = nrtp_pkg::CHAR_NUL;
      rsp_ch.ready     = 1'b0;
      clear_parser();

      // directed strings: each form, the value edges and the error paths
      put_string("");                        // empty string
      put_string("7");
      put_string("-5");                      // upper bound only
      put_string("5-");                      // lower bound only
      put_string("3-9");
      put_string("  -3");                    // blanks then minus negates
      put_string(" -0");                     // negated zero stays zero
      put_string("+12");
      for (int w = nrtp_pkg::CHAR_TAB; w <= nrtp_pkg::CHAR_CR; w++)
         text_stream.push_back(char_type'(w)); // every blank kind
      put_string(" 8");
      put_string("18446744073709551615");    // largest value
      put_string("18446744073709551616");    // overflow by one
      put_string("0-18446744073709551615");
      put_string("1-99999999999999999999");  // overflow in the second number
      put_string("-");                       // lone minus
      put_string("+");                       // sign with no digits
      put_string("   ");                     // blanks only
      put_string("1x2");                     // stray byte, rest ignored
      put_string("--1");
      put_string("1-2-3");
      put_string("-5-");
      put_string("+-1");
      put_string("1- ");
      text_stream.push_back(char_type'(8'hFF));
      text_stream.push_back(nrtp_pkg::CHAR_NUL);

      // random part: mostly well-formed ranges, some broken, some noise
      while (text_stream.size() < STREAM_BYTES) begin
         kind = $urandom_range(0, 99);
         if (kind < 70)
            put_range_string(1'b0);
         else if (kind < 85)
            put_range_string(1'b1);
         else
            put_noise();
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all words offered and taken, then every result back
      while (text_stream.size() != 0 || req_ch.valid) @(posedge clock);
      while (pending_bounds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0 && pending_bounds.size() == 0) begin
         $display("numeric_range_text_parser_unit regression: pass");
      end else begin
         $display("numeric_range_text_parser_unit regression: fail");
      end
      $finish;
   end

   // hard stop if the run hangs
   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("numeric_range_text_parser_unit regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
